// File: rtl/lmdu_pkg.sv
// lmdu_pkg: shared types and constants for the long multiply / divide unit
// used by every module of the unit; depends on nothing

package lmdu_pkg;

	localparam int unsigned HALF_BITS  = 32;
	localparam int unsigned EXT_BITS   = 16;
	localparam int unsigned EXT_SIGNED = 11;
	localparam int unsigned EXT_WIDE   = 10;
	localparam int unsigned DIV_STEPS  = 64;

	typedef enum logic {
		FUNC_MUL = 1'b0,
		FUNC_DIV = 1'b1
	} func_t;

	typedef struct packed {
		logic                   func;
		logic [HALF_BITS-1:0]   source_operand;
		logic [EXT_BITS-1:0]    extension_word;
		logic [HALF_BITS-1:0]   low_reg_value;
		logic [HALF_BITS-1:0]   high_reg_value;
	} in_word_t;

	typedef struct packed {
		logic [HALF_BITS-1:0]   low_result;
		logic [HALF_BITS-1:0]   high_result;
		logic                   write_low;
		logic                   write_high;
		logic                   divide_by_zero;
	} out_word_t;

	// classified operation handed from front to back
	typedef struct packed {
		func_t                  op;
		logic                   sgn;
		logic                   wr_hi;
		logic                   dz;
		logic                   neg_q;
		logic                   neg_r;
		logic [HALF_BITS-1:0]   src;
		logic [2*HALF_BITS-1:0] num;
	} op_word_t;

endpackage

// File: rtl/lmdu_front.sv
// lmdu_front: decodes the extension word and forms operand magnitudes for divide
// depends on lmdu_pkg

module lmdu_front (
	input  lmdu_pkg::in_word_t in_word,
	output lmdu_pkg::op_word_t op_word
);
	import lmdu_pkg::*;

	logic                   sgn;
	logic                   wide;
	logic [2*HALF_BITS-1:0] a;
	logic                   aneg;
	logic                   dneg;

	always_comb begin
		sgn  = in_word.extension_word[EXT_SIGNED];
		wide = in_word.extension_word[EXT_WIDE];
		if (wide) begin
			a = {in_word.high_reg_value, in_word.low_reg_value};
		end else begin
			a = {{HALF_BITS{sgn & in_word.low_reg_value[HALF_BITS-1]}},
				in_word.low_reg_value};
		end
		aneg = sgn & a[2*HALF_BITS-1];
		dneg = sgn & in_word.source_operand[HALF_BITS-1];
		op_word.op      = func_t'(in_word.func);
		op_word.sgn     = sgn;
		op_word.wr_hi   = wide & (in_word.extension_word[14:12] != in_word.extension_word[2:0]);
		op_word.dz      = (in_word.func == FUNC_DIV) && (in_word.source_operand == '0);
		op_word.neg_q   = aneg ^ dneg;
		op_word.neg_r   = aneg;
		if (in_word.func == FUNC_MUL) begin
			// multiply keeps raw operands, sign handled by extension
			op_word.num = {{HALF_BITS{1'b0}}, in_word.low_reg_value};
			op_word.src = in_word.source_operand;
		end else begin
			op_word.num = aneg ? (~a + 1'b1) : a;
			op_word.src = dneg ? (~in_word.source_operand + 1'b1) : in_word.source_operand;
		end
	end

endmodule

// File: rtl/lmdu_fifo.sv
// lmdu_fifo: two-entry register queue between front and back
// depends on lmdu_pkg

module lmdu_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lmdu_pkg::op_word_t push_word,
	input  logic               pop,
	output logic               empty,
	output logic               full,
	output lmdu_pkg::op_word_t pop_word
);
	import lmdu_pkg::*;

	op_word_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign empty    = (cnt_q == 2'd0);
	assign full     = (cnt_q == 2'd2);
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/lmdu_back.sv
// lmdu_back: pipelined multiply and fully pipelined restoring divide
// one radix-2 divide step per stage; depends on lmdu_pkg

module lmdu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  lmdu_pkg::op_word_t  op_word,
	output logic                out_valid,
	output lmdu_pkg::out_word_t out_word
);
	import lmdu_pkg::*;

	localparam int unsigned N  = DIV_STEPS;
	localparam int unsigned HB = HALF_BITS;

	// per stage: partial remainder, shifted dividend/quotient, divisor, control
	logic              v_q   [N+1];
	logic [HB:0]       rem_q [N+1];
	logic [2*HB-1:0]   qd_q  [N+1];
	op_word_t          ctl_q [N+1];
	logic [2*HB-1:0]   prod_q [N+1];

	logic [HB:0]       trial  [N];
	logic [HB+1:0]     diff   [N];
	logic [2*HB-1:0]   mprod;

	// signed multiply as 33x33 product, registered into stage 0
	always_comb begin
		mprod = 64'($signed({op_word.sgn & op_word.num[HB-1], op_word.num[HB-1:0]})
			* $signed({op_word.sgn & op_word.src[HB-1], op_word.src}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) v_q[i] <= 1'b0;
		end else begin
			v_q[0] <= in_valid;
			for (int i = 1; i <= N; i++) v_q[i] <= v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0]  <= '0;
		qd_q[0]   <= op_word.num;
		ctl_q[0]  <= op_word;
		prod_q[0] <= mprod;
		for (int i = 1; i <= N; i++) begin
			ctl_q[i]  <= ctl_q[i-1];
			prod_q[i] <= prod_q[i-1];
			if (diff[i-1][HB+1]) begin
				rem_q[i] <= trial[i-1];
				qd_q[i]  <= {qd_q[i-1][2*HB-2:0], 1'b0};
			end else begin
				rem_q[i] <= diff[i-1][HB:0];
				qd_q[i]  <= {qd_q[i-1][2*HB-2:0], 1'b1};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			trial[i] = {rem_q[i][HB-1:0], qd_q[i][2*HB-1]};
			diff[i]  = {1'b0, trial[i]} - {2'b00, ctl_q[i].src};
		end
	end

	logic [HB-1:0] q_lo;
	logic [HB-1:0] r_lo;

	always_comb begin
		q_lo = qd_q[N][HB-1:0];
		r_lo = rem_q[N][HB-1:0];
		out_valid = v_q[N];
		out_word  = '0;
		if (ctl_q[N].op == FUNC_MUL) begin
			out_word.low_result  = prod_q[N][HB-1:0];
			out_word.high_result = prod_q[N][2*HB-1:HB];
			out_word.write_low   = 1'b1;
			out_word.write_high  = ctl_q[N].wr_hi;
		end else if (ctl_q[N].dz) begin
			out_word.divide_by_zero = 1'b1;
		end else begin
			out_word.low_result  = ctl_q[N].neg_q ? (~q_lo + 1'b1) : q_lo;
			out_word.high_result = ctl_q[N].neg_r ? (~r_lo + 1'b1) : r_lo;
			out_word.write_low   = 1'b1;
			out_word.write_high  = ctl_q[N].wr_hi;
		end
	end

endmodule

// File: rtl/long_multiply_divide_unit_core.sv
// long_multiply_divide_unit_core: top level of the long multiply / divide unit
// depends on lmdu_pkg, lmdu_front, lmdu_fifo, lmdu_back
//
// usage
//   command channel: drive cmd and raise start; a word is taken at a clock
//   edge where start is high and busy is low
//   result channel: done pulses for one cycle with rsp; the receiver cannot
//   stall, so the back end never holds a word
// throughput: one word per cycle, sustained
// path from start to done: the front register, then the queue, then the
//   back end (one multiply stage folded alongside 64 radix-2 divide stages)
// the back end drains the queue every cycle, so the queue never holds more
//   than one word and busy stays low; it would rise only if the queue filled
// reset: arst_n clears all valid bits; in-flight words are dropped and
//   no done pulse follows until a new word is taken
// multiply and divide share one pipeline so results leave in order

module long_multiply_divide_unit_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lmdu_pkg::in_word_t  cmd,
	output logic                busy,
	output logic                done,
	output lmdu_pkg::out_word_t rsp
);
	import lmdu_pkg::*;

	op_word_t op_comb;
	op_word_t op_s1;
	logic     v_s1;
	logic     q_empty;
	logic     q_full;
	op_word_t q_word;
	logic     pop;

	// front: classify and register
	lmdu_front u_front (
		.in_word (cmd),
		.op_word (op_comb)
	);

	assign busy = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= op_comb;
	end

	// back always drains a word when one is present
	assign pop = ~q_empty;

	lmdu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1),
		.push_word (op_s1),
		.pop       (pop),
		.empty     (q_empty),
		.full      (q_full),
		.pop_word  (q_word)
	);

	lmdu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pop),
		.op_word   (q_word),
		.out_valid (done),
		.out_word  (rsp)
	);

endmodule
